FILE: src/mm4f_pkg.sv
// Shared types, opcodes and binary32 helper functions for the 4x4 float
// matrix-row multiplier. No dependencies.
package mm4f_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MUL  = 1'b1;

	localparam int MUL_LAT = 3;
	localparam int ADD_LAT = 4;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	typedef struct packed {
		logic        operation;
		logic [1:0]  row_index;
		logic [31:0] elem_x;
		logic [31:0] elem_y;
		logic [31:0] elem_z;
		logic [31:0] elem_w;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  result_row;
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [31:0] out_w;
	} res_item_t;

	typedef struct packed {
		logic        sign;
		logic [7:0]  exp;     // effective exponent, 1 for subnormals
		logic [23:0] man;     // hidden bit included
		logic        is_zero;
		logic        is_inf;
		logic        is_nan;
	} fp_unp_t;

	typedef struct packed {
		logic [47:0]        sig;
		logic signed [11:0] exp;
	} fp_norm_t;

	function automatic fp_unp_t fp_unpack(input logic [31:0] f);
		fp_unp_t u;
		u.sign    = f[31];
		u.exp     = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
		u.man     = {(f[30:23] != 8'd0), f[22:0]};
		u.is_zero = (f[30:0] == 31'd0);
		u.is_inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
		u.is_nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
		return u;
	endfunction

	// Shift the leading one up to bit 47 and adjust the exponent.
	function automatic fp_norm_t fp_normalize(input logic [47:0] sig,
			input logic signed [11:0] exp);
		logic [5:0] lz;
		fp_norm_t   r;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (sig[i]) lz = 6'(47 - i);
		end
		r.sig = sig << lz;
		r.exp = exp - $signed({6'd0, lz});
		return r;
	endfunction

	// Round to nearest even and pack. sig has its leading one at bit 47,
	// exp is the biased exponent of that bit; below 1 gives a subnormal.
	function automatic logic [31:0] fp_round_pack(input logic sign,
			input logic [47:0] sig, input logic signed [11:0] exp);
		logic [11:0] shw;
		logic [5:0]  sh;
		logic [47:0] s;
		logic        lost;
		logic [7:0]  ef;
		logic        rup;
		logic [30:0] w;
		if (exp >= 12'sd1) begin
			s    = sig;
			lost = 1'b0;
			ef   = exp[7:0];
		end else begin
			shw = 12'(12'sd1 - exp);
			ef  = 8'd0;
			if (shw >= 12'd48) begin
				s    = 48'd0;
				lost = |sig;
			end else begin
				sh   = shw[5:0];
				s    = sig >> sh;
				lost = |(sig & ~({48{1'b1}} << sh));
			end
		end
		rup = s[23] & (lost | (|s[22:0]) | s[24]);
		// carry out of the mantissa bumps the exponent field, up to inf
		w = {ef, s[46:24]} + 31'(rup);
		if (exp >= 12'sd255) return {sign, 8'hFF, 23'd0};
		return {sign, w};
	endfunction

endpackage

FILE: src/mm4f_fmul.sv
// Three-stage binary32 multiplier, round to nearest even.
// Depends on mm4f_pkg.
module mm4f_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import mm4f_pkg::*;

	fp_unp_t            ua, ub;
	logic [47:0]        prod_s1;
	logic signed [11:0] exp_s1;
	logic               sign_s1, nan_s1, inf_s1, zero_s1;
	fp_norm_t           nrm;
	fp_norm_t           nrm_s2;
	logic               sign_s2, nan_s2, inf_s2, zero_s2;
	logic [31:0]        y_s3;

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ua.man * ub.man;
			exp_s1  <= $signed({4'd0, ua.exp}) + $signed({4'd0, ub.exp}) - 12'sd126;
			sign_s1 <= ua.sign ^ ub.sign;
			nan_s1  <= ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_zero)
				| (ub.is_inf & ua.is_zero);
			inf_s1  <= ua.is_inf | ub.is_inf;
			zero_s1 <= ua.is_zero | ub.is_zero;
		end
	end

	assign nrm = fp_normalize(prod_s1, exp_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s2  <= nrm;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			zero_s2 <= zero_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (nan_s2)       y_s3 <= CANON_NAN;
			else if (inf_s2)  y_s3 <= {sign_s2, 8'hFF, 23'd0};
			else if (zero_s2) y_s3 <= {sign_s2, 31'd0};
			else              y_s3 <= fp_round_pack(sign_s2, nrm_s2.sig, nrm_s2.exp);
		end
	end

	assign y = y_s3;

endmodule

FILE: src/mm4f_fadd.sv
// Four-stage binary32 adder: align, add, normalize, round.
// Depends on mm4f_pkg.
module mm4f_fadd (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import mm4f_pkg::*;

	fp_unp_t     ua, ub, ul, us;
	logic        swap;
	logic [7:0]  d;
	logic [47:0] sig_l, sig_sm, sig_al;

	logic [47:0] sigl_s1, sigs_s1;
	logic [7:0]  exp_s1;
	logic        sign_s1, sub_s1, nan_s1, inf_s1, infs_s1, bz_s1, zs_s1;

	logic [47:0] sum_s2;
	logic [7:0]  exp_s2;
	logic        sign_s2, nan_s2, inf_s2, infs_s2, bz_s2, zs_s2;

	fp_norm_t    nrm;
	fp_norm_t    nrm_s3;
	logic        zero_s3, sign_s3, nan_s3, inf_s3, infs_s3, bz_s3, zs_s3;
	logic [31:0] y_s4;

	assign ua   = fp_unpack(a);
	assign ub   = fp_unpack(b);
	assign swap = b[30:0] > a[30:0];
	assign ul   = swap ? ub : ua;
	assign us   = swap ? ua : ub;
	assign d    = ul.exp - us.exp;
	assign sig_l  = {1'b0, ul.man, 23'd0};
	assign sig_sm = {1'b0, us.man, 23'd0};

	// smaller operand shifted right, lost bits folded into bit 0
	always_comb begin
		if (d >= 8'd48) begin
			sig_al = {47'd0, |sig_sm};
		end else begin
			sig_al = (sig_sm >> d[5:0]);
			sig_al[0] = sig_al[0] | (|(sig_sm & ~({48{1'b1}} << d[5:0])));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sigl_s1 <= sig_l;
			sigs_s1 <= sig_al;
			exp_s1  <= ul.exp;
			sign_s1 <= ul.sign;
			sub_s1  <= ua.sign ^ ub.sign;
			nan_s1  <= ua.is_nan | ub.is_nan
				| (ua.is_inf & ub.is_inf & (ua.sign != ub.sign));
			inf_s1  <= ua.is_inf | ub.is_inf;
			infs_s1 <= ua.is_inf ? ua.sign : ub.sign;
			bz_s1   <= ua.is_zero & ub.is_zero;
			zs_s1   <= ua.sign & ub.sign;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sub_s1 ? sigl_s1 - sigs_s1 : sigl_s1 + sigs_s1;
			exp_s2  <= exp_s1;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			infs_s2 <= infs_s1;
			bz_s2   <= bz_s1;
			zs_s2   <= zs_s1;
		end
	end

	// hidden bit sits at bit 46, so bit 47 carries exponent + 1
	assign nrm = fp_normalize(sum_s2, $signed({4'd0, exp_s2}) + 12'sd1);

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s3  <= nrm;
			zero_s3 <= (sum_s2 == 48'd0);
			sign_s3 <= sign_s2;
			nan_s3  <= nan_s2;
			inf_s3  <= inf_s2;
			infs_s3 <= infs_s2;
			bz_s3   <= bz_s2;
			zs_s3   <= zs_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (nan_s3)       y_s4 <= CANON_NAN;
			else if (inf_s3)  y_s4 <= {infs_s3, 8'hFF, 23'd0};
			else if (bz_s3)   y_s4 <= {zs_s3, 31'd0};
			else if (zero_s3) y_s4 <= 32'd0;
			else              y_s4 <= fp_round_pack(sign_s3, nrm_s3.sig, nrm_s3.exp);
		end
	end

	assign y = y_s4;

endmodule

FILE: src/matrix_multiply_4x4_float.sv
// Channel   Dir  Payload      Handshake
// cmd       in   cmd_item_t   cmd_valid / cmd_stall
// res       out  res_item_t   res_valid / res_stall
//
// One item per cycle while no stalled result holds the pipeline; a multiply row
// passes through the multipliers, then a chain of three adders per column.
// Loads update the stored matrix at their transfer and give no result.
// Reset clears the stored matrix to +0 and empties the pipeline.
// A stalled result freezes the whole pipeline; cmd_stall follows it.
// Depends on mm4f_pkg, mm4f_fmul, mm4f_fadd.
module matrix_multiply_4x4_float (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  mm4f_pkg::cmd_item_t cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output mm4f_pkg::res_item_t res
);
	import mm4f_pkg::*;

	localparam int LAT = MUL_LAT + 3 * ADD_LAT;

	logic [31:0]    mat_q [16];
	logic [LAT-1:0] vld_q;
	logic [1:0]     row_q [LAT];
	logic           en, accept;
	logic [31:0]    elem [4];
	logic [31:0]    prod [4][4];
	logic [31:0]    sum1 [4];
	logic [31:0]    sum2 [4];
	logic [31:0]    sum3 [4];
	logic [31:0]    p2_dly_q [4][ADD_LAT];
	logic [31:0]    p3_dly_q [4][2*ADD_LAT];

	assign en        = !vld_q[LAT-1] || !res_stall;
	assign cmd_stall = !en;
	assign accept    = cmd_valid && en;
	assign res_valid = vld_q[LAT-1];

	assign elem[0] = cmd.elem_x;
	assign elem[1] = cmd.elem_y;
	assign elem[2] = cmd.elem_z;
	assign elem[3] = cmd.elem_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= 32'd0;
		end else if (accept && cmd.operation == OP_LOAD) begin
			for (int j = 0; j < 4; j++) mat_q[{cmd.row_index, 2'(j)}] <= elem[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], accept && cmd.operation == OP_MUL};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_q[0] <= cmd.row_index;
			for (int i = 1; i < LAT; i++) row_q[i] <= row_q[i-1];
		end
	end

	// operands are taken straight from the stored matrix at transfer
	for (genvar c = 0; c < 4; c++) begin : g_col
		for (genvar k = 0; k < 4; k++) begin : g_mul
			mm4f_fmul u_mul (
				.clk (clk),
				.en  (en),
				.a   (mat_q[k*4+c]),
				.b   (elem[k]),
				.y   (prod[c][k])
			);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p2_dly_q[c][0] <= prod[c][2];
				for (int i = 1; i < ADD_LAT; i++) p2_dly_q[c][i] <= p2_dly_q[c][i-1];
				p3_dly_q[c][0] <= prod[c][3];
				for (int i = 1; i < 2*ADD_LAT; i++) p3_dly_q[c][i] <= p3_dly_q[c][i-1];
			end
		end

		mm4f_fadd u_add1 (
			.clk (clk),
			.en  (en),
			.a   (prod[c][0]),
			.b   (prod[c][1]),
			.y   (sum1[c])
		);
		mm4f_fadd u_add2 (
			.clk (clk),
			.en  (en),
			.a   (sum1[c]),
			.b   (p2_dly_q[c][ADD_LAT-1]),
			.y   (sum2[c])
		);
		mm4f_fadd u_add3 (
			.clk (clk),
			.en  (en),
			.a   (sum2[c]),
			.b   (p3_dly_q[c][2*ADD_LAT-1]),
			.y   (sum3[c])
		);
	end

	assign res.result_row = row_q[LAT-1];
	assign res.out_x      = sum3[0];
	assign res.out_y      = sum3[1];
	assign res.out_z      = sum3[2];
	assign res.out_w      = sum3[3];

`ifndef SYNTHESIS
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.operation == OP_LOAD |=> !vld_q[0])
		else $error("load transfer entered the result pipeline");
	a_mul_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.operation == OP_MUL |=> vld_q[0])
		else $error("multiply transfer lost at pipeline entry");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while frozen");
	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.out_x[30:23] == 8'hFF && res.out_x[22:0] != 23'd0
		|-> res.out_x == CANON_NAN)
		else $error("non-canonical NaN on output");
`endif

endmodule

FILE: test/testbench.sv
// Testbench for matrix_multiply_4x4_float: random and directed load and multiply
// transfers, checked against an in-bench binary32 row-times-matrix predictor.
// Depends on mm4f_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import mm4f_pkg::*;

	// Predicts result rows from the stored right matrix; exact integer float math
	class row_scoreboard;
		logic [31:0] right_mat [16];
		res_item_t   expected_rows [$];
		int          errors;

		function new();
			foreach (right_mat[i]) right_mat[i] = 32'd0;
			errors = 0;
		endfunction

		// m * 2^e rounded to nearest even into binary32
		static function logic [31:0] round_pack(input logic s, input logic [319:0] m,
				input int e);
			int p, sh, bexp;
			logic [319:0] q, rem, half;
			if (m == 0) return {s, 31'd0};
			p = 0;
			for (int i = 0; i < 320; i++) if (m[i]) p = i;
			sh = p - 23;
			if (-149 - e > sh) sh = -149 - e;
			if (sh > 0) begin
				q    = m >> sh;
				rem  = m & ((320'd1 << sh) - 1);
				half = 320'd1 << (sh - 1);
				if (rem > half || (rem == half && q[0])) q = q + 1;
			end else begin
				q = m << (-sh);
			end
			if (q >= (320'd1 << 24)) begin
				q  = q >> 1;
				sh = sh + 1;
			end
			if (q < (320'd1 << 23)) return {s, 8'd0, q[22:0]};
			bexp = sh + e + 150;
			if (bexp >= 255) return {s, 8'hFF, 23'd0};
			return {s, bexp[7:0], q[22:0]};
		endfunction

		static function logic is_nan32(input logic [31:0] f);
			return f[30:23] == 8'hFF && f[22:0] != 0;
		endfunction

		static function logic is_inf32(input logic [31:0] f);
			return f[30:23] == 8'hFF && f[22:0] == 0;
		endfunction

		static function logic [23:0] sig_of(input logic [31:0] f);
			return (f[30:23] == 0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
		endfunction

		static function int scale_of(input logic [31:0] f);
			return ((f[30:23] == 0) ? 1 : int'(f[30:23])) - 150;
		endfunction

		static function logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
			logic s;
			logic [319:0] m;
			s = a[31] ^ b[31];
			if (is_nan32(a) || is_nan32(b)) return CANON_NAN;
			if (is_inf32(a) || is_inf32(b)) begin
				if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
				return {s, 8'hFF, 23'd0};
			end
			if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
			m = 320'(sig_of(a)) * 320'(sig_of(b));
			return round_pack(s, m, scale_of(a) + scale_of(b));
		endfunction

		static function logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
			int ea, eb, emin;
			logic [319:0] ma, mb;
			if (is_nan32(a) || is_nan32(b)) return CANON_NAN;
			if (is_inf32(a) && is_inf32(b) && a[31] != b[31]) return CANON_NAN;
			if (is_inf32(a)) return a;
			if (is_inf32(b)) return b;
			if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
			ea = scale_of(a);
			eb = scale_of(b);
			emin = (ea < eb) ? ea : eb;
			ma = 320'(sig_of(a)) << (ea - emin);
			mb = 320'(sig_of(b)) << (eb - emin);
			if (a[31] == b[31]) return round_pack(a[31], ma + mb, emin);
			if (ma > mb) return round_pack(a[31], ma - mb, emin);
			if (mb > ma) return round_pack(b[31], mb - ma, emin);
			return 32'd0;
		endfunction

		function void note_transfer(input cmd_item_t c);
			logic [31:0] v [4];
			logic [31:0] col [4];
			logic [31:0] acc;
			res_item_t r;
			v = '{c.elem_x, c.elem_y, c.elem_z, c.elem_w};
			if (c.operation == OP_LOAD) begin
				for (int j = 0; j < 4; j++) right_mat[c.row_index * 4 + j] = v[j];
				return;
			end
			for (int j = 0; j < 4; j++) begin
				acc = fmul(right_mat[j], v[0]);
				for (int k = 1; k < 4; k++) acc = fadd(acc, fmul(right_mat[k * 4 + j], v[k]));
				col[j] = acc;
			end
			r.result_row = c.row_index;
			r.out_x = col[0];
			r.out_y = col[1];
			r.out_z = col[2];
			r.out_w = col[3];
			expected_rows.push_back(r);
		endfunction

		function void check_result(input res_item_t got);
			res_item_t want;
			if (expected_rows.size() == 0) begin
				$display("%0t: unexpected result row %h", $time, got);
				errors++;
				return;
			end
			want = expected_rows.pop_front();
			if (got.result_row !== want.result_row) begin
				$display("%0t: result_row expected %0d actual %0d", $time,
					want.result_row, got.result_row);
				errors++;
			end
			if (got.out_x !== want.out_x) begin
				$display("%0t: out_x expected %h actual %h", $time, want.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== want.out_y) begin
				$display("%0t: out_y expected %h actual %h", $time, want.out_y, got.out_y);
				errors++;
			end
			if (got.out_z !== want.out_z) begin
				$display("%0t: out_z expected %h actual %h", $time, want.out_z, got.out_z);
				errors++;
			end
			if (got.out_w !== want.out_w) begin
				$display("%0t: out_w expected %h actual %h", $time, want.out_w, got.out_w);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      res_valid;
	logic      res_stall;
	res_item_t res;

	row_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_req;

	matrix_multiply_4x4_float DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mix of raw patterns, tame magnitudes, specials, subnormals and huge values
	function automatic logic [31:0] pick_float();
		logic [31:0] specials [10];
		specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3F80_0000, 32'hBF80_0000,
			32'h0080_0000, 32'h7F7F_FFFF};
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3, 4, 5, 6: return {1'($urandom), 8'($urandom_range(144, 110)), 23'($urandom)};
			7: return specials[$urandom_range(9)];
			8: return {1'($urandom), 8'd0, 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(254, 240)), 23'($urandom)};
		endcase
	endfunction

	task automatic send_item(input logic op, input logic [1:0] row, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [31:0] w);
		cmd_item_t c;
		c.operation = op;
		c.row_index = row;
		c.elem_x = x;
		c.elem_y = y;
		c.elem_z = z;
		c.elem_w = w;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			cmd = {3'($urandom), $urandom, $urandom, $urandom, $urandom};
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd = c;
		do @(posedge clk); while (cmd_stall);
		sb.note_transfer(c);
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	task automatic send_random();
		send_item(($urandom_range(99) < 15) ? OP_LOAD : OP_MUL, 2'($urandom),
			pick_float(), pick_float(), pick_float(), pick_float());
	endtask

	task automatic wait_drained();
		while (sb.expected_rows.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Result side: random stalls plus a long hold-off when hold_req is set
	initial begin
		int hold_left;
		hold_left = 0;
		res_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) sb.check_result(res);
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall = 1'b1;
			end else begin
				res_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		sb = new();
		hold_req = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 82;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// multiply against the all-zero matrix straight after reset
		send_item(OP_MUL, 2'd0, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'h0000_0001);
		send_item(OP_LOAD, 2'd0, 32'h3F80_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'h0000_0001);
		send_item(OP_LOAD, 2'd1, 32'h0000_0000, 32'h7F80_0000, 32'h7F7F_FFFF, 32'h807F_FFFF);
		send_item(OP_LOAD, 2'd2, 32'hBF80_0000, 32'hFF80_0000, 32'h0080_0000, 32'h7FC0_0000);
		send_item(OP_LOAD, 2'd3, 32'h4000_0000, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h3400_0000);
		send_item(OP_MUL, 2'd0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_MUL, 2'd1, 32'h0000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_MUL, 2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_MUL, 2'd3, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_MUL, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_MUL, 2'd1, 32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'h0000_0000);
		// load followed at once by a multiply that must see it
		send_item(OP_LOAD, 2'd2, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
		send_item(OP_MUL, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'h4040_0000, 32'h0000_0000);
		send_item(OP_LOAD, 2'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_MUL, 2'd0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h7F80_0000);
		send_item(OP_MUL, 2'd0, 32'h3F80_0001, 32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 82 : 0;
			recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 14 : 0;
			for (int n = 0; n < 265; n++) begin
				if (phase == 2 && n == 20) hold_req = 1'b1;
				if (phase == 1 && n == 100) wait_drained();
				send_random();
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#3ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: matrix_multiply_4x4_float.f
src/mm4f_pkg.sv
src/mm4f_fmul.sv
src/mm4f_fadd.sv
src/matrix_multiply_4x4_float.sv
test/testbench.sv
